[rtl/sorted_priority_queue_top_macros.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Each macro expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Shared types, constants and index helpers of the sorted priority queue.
// No dependencies; used by spq_core and sorted_priority_queue_top.
package spq_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RANK_W = 16;
    localparam int TAG_W  = 32;
    localparam int FILL_W = 5;

    // Operation codes
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_spq_status;

    typedef struct packed {
        logic                     kind;
        logic signed [RANK_W-1:0] rank_in;
        logic        [TAG_W-1:0]  tag_in;
    } t_spq_in;

    typedef struct packed {
        t_spq_status              status;
        logic signed [RANK_W-1:0] rank_out;
        logic        [TAG_W-1:0]  tag_out;
        logic        [FILL_W-1:0] fill_level;
    } t_spq_out;

    // One stored queue entry
    typedef struct packed {
        logic signed [RANK_W-1:0] rank;
        logic        [TAG_W-1:0]  tag;
    } t_spq_entry;

    // Finished result offered by the core to the output register
    typedef struct packed {
        logic     valid;
        t_spq_out beat;
    } t_spq_res;

    // Circular index step backward
    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = idx - 1'b1;
        end
        return res;
    endfunction

    // Circular index step forward
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

[rtl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: valid/stall channels, output register.
// Depends on spq_pkg and spq_core.
//
// Usage:
// - Input channel: i_in_valid / o_in_stall carry one operation beat (insert with
//   rank and tag, or extract). A beat is taken when valid is high and stall low.
// - Output channel: o_out_valid / i_out_stall return exactly one result beat per
//   operation, in order: status, extracted rank and tag, and the fill level.
// - One operation is in flight at a time. A rejected insert, an empty extract or
//   an insert into an empty queue goes from the start state straight to its
//   result; an extract passes a pop state, any other insert a shift state that
//   moves each stored entry of larger rank up one slot, one entry per step as
//   the entry memory has a single write port; the next beat is taken the cycle
//   after the result is loaded into the output register.
// - A finished result sits in the output register while the next operation runs;
//   if the receiver keeps stalling, the following result waits inside the core.
// - Reset (synchronous, active low) empties the queue at once; no clearing pass.
module sorted_priority_queue_top import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_spq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_spq_out o_out_data
);

    logic     w_busy;
    logic     w_take;
    t_spq_res w_res;
    logic     r_out_valid;
    t_spq_out r_out_data;

    spq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !w_busy),
        .i_item     (i_in_data),
        .o_busy     (w_busy),
        .o_res      (w_res),
        .i_res_take (w_take)
    );

    assign o_in_stall = w_busy;

    // Load the output register when it is empty or being drained
    assign w_take = w_res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= w_res.beat;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/spq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/spq_core.sv]
// Sequencer of the sorted priority queue: entries live in a circular buffer in
// spq_ram, kept in ascending rank order. Depends on spq_pkg, spq_ram, macros.
`include "sorted_priority_queue_top_macros.svh"

module spq_core import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_spq_in  i_item,
    output logic     o_busy,
    output t_spq_res o_res,
    input  logic     i_res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    t_spq_in                  r_item, n_item;
    logic        [IDX_W-1:0]  r_head, n_head;
    logic        [CNT_W-1:0]  r_count, n_count;
    logic        [IDX_W-1:0]  r_ptr, n_ptr;
    logic        [CNT_W-1:0]  r_left, n_left;
    t_spq_status              r_status, n_status;
    logic signed [RANK_W-1:0] r_rank, n_rank;
    logic        [TAG_W-1:0]  r_tag, n_tag;

    logic                     ram_we;
    logic        [IDX_W-1:0]  ram_waddr;
    t_spq_entry               ram_wdata;
    logic        [IDX_W-1:0]  ram_raddr;
    t_spq_entry               ram_rdata;

    logic        [CNT_W:0]    w_sum;
    logic        [IDX_W-1:0]  w_tail;
    t_spq_entry               w_new;

    spq_ram #(
        .WIDTH ($bits(t_spq_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Slot just past the last stored entry
    assign w_sum  = {1'b0, r_count} + (CNT_W + 1)'(r_head);
    assign w_tail = (w_sum >= (CNT_W + 1)'(DEPTH)) ? IDX_W'(w_sum - (CNT_W + 1)'(DEPTH))
                                                   : IDX_W'(w_sum);

    assign w_new.rank = r_item.rank_in;
    assign w_new.tag  = r_item.tag_in;

    // Next-state logic and memory control
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_head    = r_head;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_status  = r_status;
        n_rank    = r_rank;
        n_tag     = r_tag;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = w_new;
        ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_status = ST_DONE;
                n_rank   = '0;
                n_tag    = '0;
                if (r_item.kind == KIND_EXTRACT) begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        ram_raddr = r_head;
                        n_state   = S_POP;
                    end
                end else begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_count == '0) begin
                        // empty queue: drop the entry straight into the tail slot
                        ram_we    = 1'b1;
                        ram_waddr = w_tail;
                        n_count   = r_count + 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        // open the hole at the tail and fetch its lower neighbor
                        n_ptr     = w_tail;
                        n_left    = r_count;
                        ram_raddr = idx_prev(w_tail);
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_POP: begin
                n_rank  = ram_rdata.rank;
                n_tag   = ram_rdata.tag;
                n_head  = idx_next(r_head);
                n_count = r_count - 1'b1;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                if (ram_rdata.rank > r_item.rank_in) begin
                    // move the larger entry up into the hole, prefetch the next one
                    ram_we    = 1'b1;
                    ram_waddr = r_ptr;
                    ram_wdata = ram_rdata;
                    n_ptr     = idx_prev(r_ptr);
                    n_left    = r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_raddr = idx_prev(idx_prev(r_ptr));
                    end
                end else begin
                    // equal or smaller rank stays below: place the new entry here
                    ram_we    = 1'b1;
                    ram_waddr = r_ptr;
                    n_count   = r_count + 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                n_count   = r_count + 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_status <= n_status;
        r_rank   <= n_rank;
        r_tag    <= n_tag;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_busy                = (r_state != S_IDLE);
    assign o_res.valid           = (r_state == S_DONE);
    assign o_res.beat.status     = r_status;
    assign o_res.beat.rank_out   = r_rank;
    assign o_res.beat.tag_out    = r_tag;
    assign o_res.beat.fill_level = FILL_W'(r_count);

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT_NOW(a_shift_left, r_state == S_SHIFT, r_left != '0, "shift with no entry left")
    `SPQ_ASSERT_NEXT(a_pop_count, r_state == S_POP,
        r_count == CNT_W'($past(r_count) - 1'b1), "pop did not drop occupancy")
    `SPQ_ASSERT_NEXT(a_full_hold,
        r_state == S_START && r_item.kind == KIND_INSERT && r_count == CNT_W'(DEPTH),
        $stable(r_count) && r_status == ST_FULL, "rejected insert changed queue")

endmodule
